### rtl/ljpe_pkg.sv
// Shared types and constants for the Lennard-Jones pair energy block.
package ljpe_pkg;

   typedef enum logic [1:0] {
      CMD_WRITE_PARTICLE = 2'd0,
      CMD_WRITE_PAIR     = 2'd1,
      CMD_QUERY          = 2'd2,
      CMD_UNUSED         = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      CSR_BOX_X     = 3'd0,
      CSR_BOX_Y     = 3'd1,
      CSR_BOX_Z     = 3'd2,
      CSR_CUTOFF_SQ = 3'd3,
      CSR_COUNT     = 3'd4
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SELF_RD,
      ST_SELF_LD,
      ST_FETCH,
      ST_LOAD,
      ST_MUL,
      ST_ADD,
      ST_POST,
      ST_R2CHK,
      ST_DIV,
      ST_ACCUM,
      ST_DONE
   } state_type;

   typedef enum logic [2:0] {
      STEP_SQX,
      STEP_SQY,
      STEP_SQZ,
      STEP_S2,
      STEP_S3,
      STEP_S6,
      STEP_V
   } step_type;

   localparam logic signed [65:0] E_MAX = 66'sd140737488355327;
   localparam logic signed [65:0] E_MIN = -66'sd140737488355328;

   localparam logic [30:0] BOX_X_RST     = 31'd3932160;
   localparam logic [30:0] BOX_Y_RST     = 31'd1310720;
   localparam logic [30:0] BOX_Z_RST     = 31'd1310720;
   localparam logic [31:0] CUTOFF_SQ_RST = 32'd82570;

endpackage

### rtl/ljpe_if.sv
// Request and response channel interfaces.
interface ljpe_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         command;
   logic [9:0]         particle_index;
   logic [1:0]         particle_type;
   logic signed [31:0] pos_x;
   logic signed [31:0] pos_y;
   logic signed [31:0] pos_z;
   logic [1:0]         first_type;
   logic [1:0]         second_type;
   logic [31:0]        sigma_sq;
   logic [31:0]        four_epsilon;
   logic signed [31:0] energy_shift;

   modport source (
      output valid, command, particle_index, particle_type, pos_x, pos_y, pos_z,
             first_type, second_type, sigma_sq, four_epsilon, energy_shift,
      input  ready
   );
   modport sink (
      input  valid, command, particle_index, particle_type, pos_x, pos_y, pos_z,
             first_type, second_type, sigma_sq, four_epsilon, energy_shift,
      output ready
   );
endinterface

interface ljpe_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [47:0] energy;
   logic               saturated;

   modport source (output valid, energy, saturated, input ready);
   modport sink (input valid, energy, saturated, output ready);
endinterface

### rtl/lj_particle_energy_min_image.sv
// Truncated shifted Lennard-Jones energy of one particle in a periodic box.
//
// req_if carries commands: write a particle slot, write a pair coefficient
// entry, or query the energy of one slot. Writes give no
// word on rsp_if. A query gives one word on rsp_if: the Q31.16 energy sum
// and a saturation flag.
// The csr_ port writes box lengths, squared cutoff and particle count.
// A query walks slots 0 .. count-1 through one shared 32x32 multiplier and
// a one-bit-per-cycle divider. A pair outside the cutoff takes the fetch,
// load, three squares and a cutoff check; a pair inside adds the divide,
// four multiplies and an accumulate. The queried slot itself is skipped.
// req_if is ready only in idle; one query runs at a time.
// The result is held in rsp_if until taken; a stalled receiver holds the
// block in that state. Reset restores register defaults and idles the
// sequencer; particle and pair stores are not cleared.
module lj_particle_energy_min_image #(
   parameter int MAX_PARTICLES = 1024,
   parameter int NUM_TYPES     = 2
) (
   input  logic                  clock,
   input  logic                  reset,
   ljpe_req_if.sink              req_if,
   ljpe_rsp_if.source            rsp_if,
   input  logic                  csr_we,
   input  ljpe_pkg::csr_index_type csr_index,
   input  logic [31:0]           csr_wdata
);
   import ljpe_pkg::*;

   localparam int AW = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
   localparam int CW = $clog2(MAX_PARTICLES + 1);
   localparam int TW = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1;
   localparam int NP = NUM_TYPES * NUM_TYPES;
   localparam int PW = (NP > 1) ? $clog2(NP) : 1;

   function automatic logic [TW-1:0] species(input logic [1:0] t);
      logic [31:0] v;
      v = 32'(t);
      if (v == 0) return '0;
      if (v > NUM_TYPES) return TW'(NUM_TYPES - 1);
      return TW'(v - 1);
   endfunction

   function automatic logic [PW-1:0] pair_idx(input logic [TW-1:0] a,
                                              input logic [TW-1:0] b);
      return PW'(32'(a) * NUM_TYPES + 32'(b));
   endfunction

   // minimum image separation, returned as magnitude
   function automatic logic [31:0] min_img(input logic signed [31:0] a,
                                           input logic signed [31:0] b,
                                           input logic [30:0] box);
      logic signed [33:0] d;
      logic signed [33:0] l;
      logic signed [34:0] d2;
      logic signed [34:0] l2;
      d  = 34'(a) - 34'(b);
      l  = $signed({3'b000, box});
      d2 = $signed({d, 1'b0});
      l2 = 35'(l);
      if (d2 > l2) d = d - l;
      else if (d2 < -l2) d = d + l;
      if (d < 0) d = -d;
      return d[31:0];
   endfunction

   // configuration
   logic [30:0] box_x_ff, box_y_ff, box_z_ff;
   logic [31:0] cutoff_ff;
   logic [CW-1:0] cnt_ff;
   logic [31:0] cnt_val;

   assign cnt_val = 32'(csr_wdata[10:0]);

   always_ff @(posedge clock) begin
      if (reset) begin
         box_x_ff  <= BOX_X_RST;
         box_y_ff  <= BOX_Y_RST;
         box_z_ff  <= BOX_Z_RST;
         cutoff_ff <= CUTOFF_SQ_RST;
         cnt_ff    <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_BOX_X:     box_x_ff <= csr_wdata[30:0];
            CSR_BOX_Y:     box_y_ff <= csr_wdata[30:0];
            CSR_BOX_Z:     box_z_ff <= csr_wdata[30:0];
            CSR_CUTOFF_SQ: cutoff_ff <= csr_wdata;
            CSR_COUNT:     cnt_ff <= (cnt_val > MAX_PARTICLES) ? CW'(MAX_PARTICLES)
                                                               : CW'(cnt_val);
            default: ;
         endcase
      end
   end

   // stores
   logic [31:0]   mem_x [MAX_PARTICLES];
   logic [31:0]   mem_y [MAX_PARTICLES];
   logic [31:0]   mem_z [MAX_PARTICLES];
   logic [TW-1:0] mem_t [MAX_PARTICLES];
   logic [31:0]   tab_sig [NP];
   logic [31:0]   tab_fe  [NP];
   logic [31:0]   tab_sh  [NP];

   logic [31:0]   rdx_ff, rdy_ff, rdz_ff;
   logic [TW-1:0] rdt_ff;
   logic [AW-1:0] raddr;
   logic [AW-1:0] waddr;
   logic          mem_we, tab_we;
   logic [31:0]   req_idx32;
   logic          req_idx_ok;

   assign req_idx32  = 32'(req_if.particle_index);
   assign req_idx_ok = req_idx32 < MAX_PARTICLES;
   assign waddr      = req_idx32[AW-1:0];

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_x[waddr] <= req_if.pos_x;
         mem_y[waddr] <= req_if.pos_y;
         mem_z[waddr] <= req_if.pos_z;
         mem_t[waddr] <= species(req_if.particle_type);
      end
      rdx_ff <= mem_x[raddr];
      rdy_ff <= mem_y[raddr];
      rdz_ff <= mem_z[raddr];
      rdt_ff <= mem_t[raddr];
   end

   always_ff @(posedge clock) begin
      if (tab_we) begin
         tab_sig[pair_idx(species(req_if.first_type), species(req_if.second_type))]
            <= req_if.sigma_sq;
         tab_fe[pair_idx(species(req_if.first_type), species(req_if.second_type))]
            <= req_if.four_epsilon;
         tab_sh[pair_idx(species(req_if.first_type), species(req_if.second_type))]
            <= req_if.energy_shift;
      end
   end

   // sequencer and datapath
   state_type state_ff, state_in;
   step_type  step_ff, step_in;
   logic [9:0]    idx_ff, idx_in;
   logic [31:0]   selfx_ff, selfx_in, selfy_ff, selfy_in, selfz_ff, selfz_in;
   logic [TW-1:0] selft_ff, selft_in;
   logic [CW-1:0] j_ff, j_in;
   logic [31:0]   ady_ff, ady_in, adz_ff, adz_in;
   logic [31:0]   sig_ff, sig_in, fe_ff, fe_in;
   logic signed [31:0] sh_ff, sh_in;
   logic [63:0]   mul_a_ff, mul_a_in, mul_b_ff, mul_b_in;
   logic [1:0]    k_ff, k_in;
   logic [63:0]   pp_ff, pp_in;
   logic [127:0]  acc_ff, acc_in;
   logic [65:0]   r2sum_ff, r2sum_in;
   logic [47:0]   num_ff, num_in, q_ff, q_in;
   logic [49:0]   rem_ff, rem_in, dvs_ff, dvs_in;
   logic [5:0]    dcnt_ff, dcnt_in;
   logic [63:0]   s_ff, s_in, s3_ff, s3_in;
   logic          neg_ff, neg_in, huge_ff, huge_in;
   logic signed [65:0] v_ff, v_in;
   logic signed [47:0] sum_ff, sum_in;
   logic          sat_ff, sat_in;

   logic [31:0]   idx32;
   logic [31:0]   a_part, b_part;
   logic [6:0]    shamt;
   logic          ovf;
   logic [63:0]   res;
   logic [49:0]   r2;
   logic [50:0]   trial;
   logic          ge;
   logic signed [65:0] t;
   logic [PW-1:0] p;

   assign idx32  = 32'(idx_ff);
   assign a_part = k_ff[0] ? mul_a_ff[63:32] : mul_a_ff[31:0];
   assign b_part = k_ff[1] ? mul_b_ff[63:32] : mul_b_ff[31:0];
   assign shamt  = 7'((32'(k_ff[0]) + 32'(k_ff[1])) * 32);
   assign ovf    = |acc_ff[127:80];
   assign res    = acc_ff[79:16];
   assign r2     = r2sum_ff[65:16];
   assign trial  = {rem_ff, num_ff[47]};
   assign ge     = trial >= {1'b0, dvs_ff};
   assign t      = 66'(sum_ff) + v_ff - 66'(sh_ff);
   assign p      = pair_idx(selft_ff, rdt_ff);

   assign req_if.ready     = (state_ff == ST_IDLE);
   assign rsp_if.valid     = (state_ff == ST_DONE);
   assign rsp_if.energy    = sum_ff;
   assign rsp_if.saturated = sat_ff;

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      idx_in   = idx_ff;
      selfx_in = selfx_ff;
      selfy_in = selfy_ff;
      selfz_in = selfz_ff;
      selft_in = selft_ff;
      j_in     = j_ff;
      ady_in   = ady_ff;
      adz_in   = adz_ff;
      sig_in   = sig_ff;
      fe_in    = fe_ff;
      sh_in    = sh_ff;
      mul_a_in = mul_a_ff;
      mul_b_in = mul_b_ff;
      k_in     = k_ff;
      pp_in    = pp_ff;
      acc_in   = acc_ff;
      r2sum_in = r2sum_ff;
      num_in   = num_ff;
      q_in     = q_ff;
      rem_in   = rem_ff;
      dvs_in   = dvs_ff;
      dcnt_in  = dcnt_ff;
      s_in     = s_ff;
      s3_in    = s3_ff;
      neg_in   = neg_ff;
      huge_in  = huge_ff;
      v_in     = v_ff;
      sum_in   = sum_ff;
      sat_in   = sat_ff;
      mem_we   = 1'b0;
      tab_we   = 1'b0;
      raddr    = j_ff[AW-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            if (req_if.valid) begin
               priority case (cmd_type'(req_if.command))
                  CMD_WRITE_PARTICLE: mem_we = req_idx_ok;
                  CMD_WRITE_PAIR:     tab_we = 1'b1;
                  CMD_QUERY: begin
                     idx_in   = req_if.particle_index;
                     sum_in   = '0;
                     sat_in   = 1'b0;
                     state_in = req_idx_ok ? ST_SELF_RD : ST_DONE;
                  end
                  default: ;
               endcase
            end
         end
         ST_SELF_RD: begin
            raddr    = idx32[AW-1:0];
            state_in = ST_SELF_LD;
         end
         ST_SELF_LD: begin
            selfx_in = rdx_ff;
            selfy_in = rdy_ff;
            selfz_in = rdz_ff;
            selft_in = rdt_ff;
            j_in     = '0;
            state_in = ST_FETCH;
         end
         ST_FETCH: begin
            if (32'(j_ff) >= 32'(cnt_ff)) begin
               state_in = ST_DONE;
            end else if (32'(j_ff) == idx32) begin
               j_in = j_ff + 1'b1;
            end else begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            mul_a_in = 64'(min_img($signed(selfx_ff), $signed(rdx_ff), box_x_ff));
            mul_b_in = 64'(min_img($signed(selfx_ff), $signed(rdx_ff), box_x_ff));
            ady_in   = min_img($signed(selfy_ff), $signed(rdy_ff), box_y_ff);
            adz_in   = min_img($signed(selfz_ff), $signed(rdz_ff), box_z_ff);
            sig_in   = tab_sig[p];
            fe_in    = tab_fe[p];
            sh_in    = $signed(tab_sh[p]);
            huge_in  = 1'b0;
            r2sum_in = '0;
            acc_in   = '0;
            k_in     = '0;
            step_in  = STEP_SQX;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            pp_in    = 64'(a_part) * 64'(b_part);
            state_in = ST_ADD;
         end
         ST_ADD: begin
            acc_in = acc_ff + (128'(pp_ff) << shamt);
            if (k_ff == 2'd3) begin
               state_in = ST_POST;
            end else begin
               k_in     = k_ff + 1'b1;
               state_in = ST_MUL;
            end
         end
         ST_POST: begin
            acc_in   = '0;
            k_in     = '0;
            state_in = ST_MUL;
            unique case (step_ff)
               STEP_SQX: begin
                  r2sum_in = acc_ff[65:0];
                  mul_a_in = 64'(ady_ff);
                  mul_b_in = 64'(ady_ff);
                  step_in  = STEP_SQY;
               end
               STEP_SQY: begin
                  r2sum_in = r2sum_ff + acc_ff[65:0];
                  mul_a_in = 64'(adz_ff);
                  mul_b_in = 64'(adz_ff);
                  step_in  = STEP_SQZ;
               end
               STEP_SQZ: begin
                  r2sum_in = r2sum_ff + acc_ff[65:0];
                  state_in = ST_R2CHK;
               end
               STEP_S2: begin
                  if (ovf) begin
                     huge_in  = 1'b1;
                     state_in = ST_ACCUM;
                  end else begin
                     mul_a_in = res;
                     mul_b_in = s_ff;
                     step_in  = STEP_S3;
                  end
               end
               STEP_S3: begin
                  if (ovf) begin
                     huge_in  = 1'b1;
                     state_in = ST_ACCUM;
                  end else begin
                     s3_in    = res;
                     mul_a_in = res;
                     mul_b_in = res;
                     step_in  = STEP_S6;
                  end
               end
               STEP_S6: begin
                  if (ovf) begin
                     huge_in  = 1'b1;
                     state_in = ST_ACCUM;
                  end else begin
                     neg_in   = res < s3_ff;
                     mul_a_in = 64'(fe_ff);
                     mul_b_in = (res < s3_ff) ? s3_ff - res : res - s3_ff;
                     step_in  = STEP_V;
                  end
               end
               default: begin
                  // pair energy from four_eps times the power difference
                  if (!neg_ff) begin
                     if (ovf || $signed({2'b00, res}) > E_MAX) begin
                        v_in   = E_MAX;
                        sat_in = 1'b1;
                     end else begin
                        v_in = $signed({2'b00, res});
                     end
                  end else if (ovf) begin
                     v_in = 66'sd1;
                  end else begin
                     v_in = -$signed({2'b00, res});
                  end
                  state_in = ST_ACCUM;
               end
            endcase
         end
         ST_R2CHK: begin
            if ({14'b0, r2} >= 64'(cutoff_ff)) begin
               j_in     = j_ff + 1'b1;
               state_in = ST_FETCH;
            end else begin
               dvs_in   = (r2 == '0) ? 50'd1 : r2;
               num_in   = {sig_ff, 16'b0};
               rem_in   = '0;
               q_in     = '0;
               dcnt_in  = 6'd47;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            rem_in = ge ? 50'(trial - {1'b0, dvs_ff}) : trial[49:0];
            q_in   = {q_ff[46:0], ge};
            num_in = {num_ff[46:0], 1'b0};
            if (dcnt_ff == '0) begin
               s_in     = 64'({q_ff[46:0], ge});
               mul_a_in = 64'({q_ff[46:0], ge});
               mul_b_in = 64'({q_ff[46:0], ge});
               acc_in   = '0;
               k_in     = '0;
               step_in  = STEP_S2;
               state_in = ST_MUL;
            end else begin
               dcnt_in = dcnt_ff - 1'b1;
            end
         end
         ST_ACCUM: begin
            if (huge_ff) begin
               // huge repulsion: pinned at the max unless four_eps is zero
               v_in     = (fe_ff != '0) ? E_MAX : 66'sd0;
               sat_in   = sat_ff | (fe_ff != '0);
               huge_in  = 1'b0;
               state_in = ST_ACCUM;
            end else begin
               if (t > E_MAX) begin
                  sum_in = E_MAX[47:0];
                  sat_in = 1'b1;
               end else if (t < E_MIN) begin
                  sum_in = E_MIN[47:0];
                  sat_in = 1'b1;
               end else begin
                  sum_in = t[47:0];
               end
               j_in     = j_ff + 1'b1;
               state_in = ST_FETCH;
            end
         end
         ST_DONE: begin
            if (rsp_if.ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= STEP_SQX;
         huge_ff  <= 1'b0;
         sat_ff   <= 1'b0;
         sum_ff   <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         huge_ff  <= huge_in;
         sat_ff   <= sat_in;
         sum_ff   <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff   <= idx_in;
      selfx_ff <= selfx_in;
      selfy_ff <= selfy_in;
      selfz_ff <= selfz_in;
      selft_ff <= selft_in;
      j_ff     <= j_in;
      ady_ff   <= ady_in;
      adz_ff   <= adz_in;
      sig_ff   <= sig_in;
      fe_ff    <= fe_in;
      sh_ff    <= sh_in;
      mul_a_ff <= mul_a_in;
      mul_b_ff <= mul_b_in;
      k_ff     <= k_in;
      pp_ff    <= pp_in;
      acc_ff   <= acc_in;
      r2sum_ff <= r2sum_in;
      num_ff   <= num_in;
      q_ff     <= q_in;
      rem_ff   <= rem_in;
      dvs_ff   <= dvs_in;
      dcnt_ff  <= dcnt_in;
      s_ff     <= s_in;
      s3_ff    <= s3_in;
      neg_ff   <= neg_in;
      v_ff     <= v_in;
   end

endmodule
